// ===== design/tlpi_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpi_pkg: shared types, codes and tables of the pendulum integrator
// Beat structs, operation and operand codes, the sequencer program,
// the arctangent table in turn units and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package tlpi_pkg;

   typedef struct packed {
      logic        func;
      logic [31:0] start_angle_one;
      logic [31:0] start_angle_two;
   } req_type;

   typedef struct packed {
      logic        [31:0] angle_one;
      logic        [31:0] angle_two;
      logic signed [31:0] rate_one;
      logic signed [31:0] rate_two;
      logic signed [31:0] bob_one_x;
      logic signed [31:0] bob_one_y;
      logic signed [31:0] bob_two_x;
      logic signed [31:0] bob_two_y;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_MUL  = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_DIV  = 3'd3,
      OP_DAMP = 3'd4,
      OP_ADV  = 3'd5,
      OP_TRIG = 3'd6
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [4:0] dst;
      logic [4:0] src_a;
      logic [4:0] src_b;
   } uop_type;

   // register file entries
   localparam logic [4:0] R0  = 5'd0;
   localparam logic [4:0] R1  = 5'd1;
   localparam logic [4:0] R2  = 5'd2;
   localparam logic [4:0] R3  = 5'd3;
   localparam logic [4:0] R4  = 5'd4;
   localparam logic [4:0] R5  = 5'd5;
   localparam logic [4:0] R6  = 5'd6;
   localparam logic [4:0] R7  = 5'd7;
   localparam logic [4:0] R8  = 5'd8;
   localparam logic [4:0] R9  = 5'd9;
   localparam logic [4:0] R10 = 5'd10;
   localparam logic [4:0] R11 = 5'd11;
   localparam logic [4:0] R12 = 5'd12;
   localparam logic [4:0] R13 = 5'd13;
   localparam logic [4:0] R14 = 5'd14;
   localparam logic [4:0] R15 = 5'd15;

   // named sources
   localparam logic [4:0] SRC_L1   = 5'd16;
   localparam logic [4:0] SRC_L2   = 5'd17;
   localparam logic [4:0] SRC_M1   = 5'd18;
   localparam logic [4:0] SRC_M2   = 5'd19;
   localparam logic [4:0] SRC_G    = 5'd20;
   localparam logic [4:0] SRC_W1   = 5'd21;
   localparam logic [4:0] SRC_W2   = 5'd22;
   localparam logic [4:0] SRC_PX   = 5'd23;
   localparam logic [4:0] SRC_PY   = 5'd24;
   localparam logic [4:0] SRC_ZERO = 5'd25;
   localparam logic [4:0] SRC_B1X  = 5'd26;
   localparam logic [4:0] SRC_B1Y  = 5'd27;

   // named destinations
   localparam logic [4:0] DST_W1  = 5'd16;
   localparam logic [4:0] DST_W2  = 5'd17;
   localparam logic [4:0] DST_A1  = 5'd18;
   localparam logic [4:0] DST_A2  = 5'd19;
   localparam logic [4:0] DST_B1X = 5'd20;
   localparam logic [4:0] DST_B1Y = 5'd21;
   localparam logic [4:0] DST_B2X = 5'd22;
   localparam logic [4:0] DST_B2Y = 5'd23;

   // trig angle selectors
   localparam logic [4:0] ANG_T1  = 5'd0;
   localparam logic [4:0] ANG_T2  = 5'd1;
   localparam logic [4:0] ANG_D   = 5'd2;
   localparam logic [4:0] ANG_T12 = 5'd3;
   localparam logic [4:0] ANG_2D  = 5'd4;

   // csr register indexes
   localparam logic [3:0] CSR_ARM_LENGTH_ONE = 4'd0;
   localparam logic [3:0] CSR_ARM_LENGTH_TWO = 4'd1;
   localparam logic [3:0] CSR_BOB_MASS_ONE   = 4'd2;
   localparam logic [3:0] CSR_BOB_MASS_TWO   = 4'd3;
   localparam logic [3:0] CSR_GRAVITY_ACCEL  = 4'd4;
   localparam logic [3:0] CSR_DAMPING_FACTOR = 4'd5;
   localparam logic [3:0] CSR_PIVOT_X        = 4'd6;
   localparam logic [3:0] CSR_PIVOT_Y        = 4'd7;

   localparam int PC_BITS  = 6;
   localparam int PROG_LEN = 56;

   localparam logic signed [31:0] RAD_TO_TURN = 32'sd683565276;
   localparam logic signed [33:0] TRIG_GAIN   = 34'sd652032874;
   localparam logic signed [31:0] Q_MAX       = 32'sh7fffffff;
   localparam logic signed [31:0] Q_MIN       = 32'sh80000000;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return Q_MAX;
      end else if (v < -66'sd2147483648) begin
         return Q_MIN;
      end else begin
         return v[31:0];
      end
   endfunction

   function automatic logic [29:0] atan_turn(input logic [4:0] idx);
      logic [29:0] r;
      case (idx)
         5'd0:  r = 30'd536870912;
         5'd1:  r = 30'd316933406;
         5'd2:  r = 30'd167458907;
         5'd3:  r = 30'd85004756;
         5'd4:  r = 30'd42667331;
         5'd5:  r = 30'd21354465;
         5'd6:  r = 30'd10679838;
         5'd7:  r = 30'd5340245;
         5'd8:  r = 30'd2670163;
         5'd9:  r = 30'd1335087;
         5'd10: r = 30'd667544;
         5'd11: r = 30'd333772;
         5'd12: r = 30'd166886;
         5'd13: r = 30'd83443;
         5'd14: r = 30'd41722;
         5'd15: r = 30'd20861;
         5'd16: r = 30'd10430;
         5'd17: r = 30'd5215;
         5'd18: r = 30'd2608;
         5'd19: r = 30'd1304;
         5'd20: r = 30'd652;
         5'd21: r = 30'd326;
         5'd22: r = 30'd163;
         5'd23: r = 30'd81;
         5'd24: r = 30'd41;
         5'd25: r = 30'd20;
         5'd26: r = 30'd10;
         5'd27: r = 30'd5;
         5'd28: r = 30'd3;
         5'd29: r = 30'd1;
         5'd30: r = 30'd1;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

   function automatic uop_type mk(input op_type op, input logic [4:0] d,
                                  input logic [4:0] a, input logic [4:0] b);
      uop_type u;
      u.op    = op;
      u.dst   = d;
      u.src_a = a;
      u.src_b = b;
      return u;
   endfunction

   function automatic uop_type prog_rom(input logic [PC_BITS-1:0] pc);
      uop_type u;
      case (pc)
         6'd0:  u = mk(OP_TRIG, R0,  ANG_T1,  SRC_ZERO);
         6'd1:  u = mk(OP_TRIG, R2,  ANG_D,   SRC_ZERO);
         6'd2:  u = mk(OP_TRIG, R4,  ANG_T12, SRC_ZERO);
         6'd3:  u = mk(OP_TRIG, R5,  ANG_2D,  SRC_ZERO);
         6'd4:  u = mk(OP_MUL,  R7,  SRC_W1,  SRC_W1);
         6'd5:  u = mk(OP_MUL,  R8,  SRC_W2,  SRC_W2);
         6'd6:  u = mk(OP_ADD,  R9,  SRC_M1,  SRC_M1);
         6'd7:  u = mk(OP_ADD,  R9,  R9,      SRC_M2);
         6'd8:  u = mk(OP_ADD,  R10, SRC_M1,  SRC_M2);
         6'd9:  u = mk(OP_MUL,  R11, SRC_M2,  R6);
         6'd10: u = mk(OP_SUB,  R11, R9,      R11);
         6'd11: u = mk(OP_MUL,  R12, SRC_G,   R9);
         6'd12: u = mk(OP_MUL,  R12, R12,     R0);
         6'd13: u = mk(OP_SUB,  R12, SRC_ZERO, R12);
         6'd14: u = mk(OP_MUL,  R13, SRC_M2,  SRC_G);
         6'd15: u = mk(OP_MUL,  R13, R13,     R4);
         6'd16: u = mk(OP_SUB,  R13, SRC_ZERO, R13);
         6'd17: u = mk(OP_ADD,  R12, R12,     R13);
         6'd18: u = mk(OP_SUB,  R13, SRC_ZERO, R2);
         6'd19: u = mk(OP_SUB,  R13, R13,     R2);
         6'd20: u = mk(OP_MUL,  R13, R13,     SRC_M2);
         6'd21: u = mk(OP_MUL,  R14, R8,      SRC_L2);
         6'd22: u = mk(OP_MUL,  R15, R7,      SRC_L1);
         6'd23: u = mk(OP_MUL,  R5,  R15,     R3);
         6'd24: u = mk(OP_ADD,  R5,  R14,     R5);
         6'd25: u = mk(OP_MUL,  R5,  R13,     R5);
         6'd26: u = mk(OP_ADD,  R12, R12,     R5);
         6'd27: u = mk(OP_MUL,  R13, SRC_L1,  R11);
         6'd28: u = mk(OP_DIV,  R12, R12,     R13);
         6'd29: u = mk(OP_ADD,  R0,  R2,      R2);
         6'd30: u = mk(OP_MUL,  R15, R15,     R10);
         6'd31: u = mk(OP_MUL,  R13, SRC_G,   R10);
         6'd32: u = mk(OP_MUL,  R13, R13,     R1);
         6'd33: u = mk(OP_MUL,  R14, R14,     SRC_M2);
         6'd34: u = mk(OP_MUL,  R14, R14,     R3);
         6'd35: u = mk(OP_ADD,  R15, R15,     R13);
         6'd36: u = mk(OP_ADD,  R15, R15,     R14);
         6'd37: u = mk(OP_MUL,  R15, R0,      R15);
         6'd38: u = mk(OP_MUL,  R13, SRC_L2,  R11);
         6'd39: u = mk(OP_DIV,  R13, R15,     R13);
         6'd40: u = mk(OP_ADD,  R12, SRC_W1,  R12);
         6'd41: u = mk(OP_DAMP, DST_W1, R12,  SRC_ZERO);
         6'd42: u = mk(OP_ADD,  R13, SRC_W2,  R13);
         6'd43: u = mk(OP_DAMP, DST_W2, R13,  SRC_ZERO);
         6'd44: u = mk(OP_ADV,  DST_A1, SRC_W1, SRC_ZERO);
         6'd45: u = mk(OP_ADV,  DST_A2, SRC_W2, SRC_ZERO);
         6'd46: u = mk(OP_TRIG, R0,  ANG_T1,  SRC_ZERO);
         6'd47: u = mk(OP_TRIG, R2,  ANG_T2,  SRC_ZERO);
         6'd48: u = mk(OP_MUL,  R4,  SRC_L1,  R0);
         6'd49: u = mk(OP_ADD,  DST_B1X, SRC_PX, R4);
         6'd50: u = mk(OP_MUL,  R4,  SRC_L1,  R1);
         6'd51: u = mk(OP_ADD,  DST_B1Y, SRC_PY, R4);
         6'd52: u = mk(OP_MUL,  R4,  SRC_L2,  R2);
         6'd53: u = mk(OP_ADD,  DST_B2X, SRC_B1X, R4);
         6'd54: u = mk(OP_MUL,  R4,  SRC_L2,  R3);
         6'd55: u = mk(OP_ADD,  DST_B2Y, SRC_B1Y, R4);
         default: u = mk(OP_ADD, R0, SRC_ZERO, SRC_ZERO);
      endcase
      return u;
   endfunction

endpackage

// ===== design/two_link_pendulum_integrator_core.sv =====
// ----------------------------------------------------------------------------
// two_link_pendulum_integrator_core: double pendulum Euler step engine
// A small sequencer runs a fixed program over a 16-entry register file,
// one shared multiplier, a CORDIC rotator and a radix-2 divider.
// ----------------------------------------------------------------------------
// One request beat is one time tick and yields one response beat. The block
// takes a beat only while idle; the tick then runs 56 program steps in
// sequence: each step passes through a fetch, an execute and a write-back
// state, a multiply adds a result state, each of the six sine/cosine steps
// adds the CORDIC rotation steps plus a second write, and each of the two
// divisions adds the radix-2 divide steps unless the divisor is zero. The
// response sits in an output register, so the next request is taken while it
// waits. CSR writes are taken while the block is idle.
module two_link_pendulum_integrator_core
   import tlpi_pkg::*;
#(
   parameter int FRAC_BITS  = 16,
   parameter int ANGLE_BITS = 32,
   parameter int TRIG_STEPS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [27:0] csr_data
);

   localparam int NSTEP   = (TRIG_STEPS < 32) ? TRIG_STEPS : 32;
   localparam int TCW     = $clog2(NSTEP + 1);
   localparam int DW      = 32 + FRAC_BITS;
   localparam int DCW     = $clog2(DW + 1);
   localparam int ADV_SH  = FRAC_BITS + 32 - ANGLE_BITS;
   localparam int TRIG_SH = 30 - FRAC_BITS;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_FETCH  = 9'b000000010,
      ST_EXEC   = 9'b000000100,
      ST_MRES   = 9'b000001000,
      ST_DIV    = 9'b000010000,
      ST_TRIG   = 9'b000100000,
      ST_WRITE  = 9'b001000000,
      ST_WRITE2 = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [PC_BITS-1:0] pc_ff, pc_in;
   uop_type uop_ff, uop_in;
   uop_type fetch_uop;

   logic signed [31:0] rf [16];
   logic signed [31:0] rfa_ff, rfb_ff;
   logic        rf_we;
   logic [3:0]  rf_waddr;
   logic signed [31:0] rf_wdata;

   logic [26:0] len1_ff, len1_in, len2_ff, len2_in;
   logic [26:0] mass1_ff, mass1_in, mass2_ff, mass2_in, grav_ff, grav_in;
   logic [16:0] damp_ff, damp_in;
   logic signed [27:0] pivx_ff, pivx_in, pivy_ff, pivy_in;

   logic [ANGLE_BITS-1:0] angle_one_ff, angle_one_in, angle_two_ff, angle_two_in;
   logic signed [31:0] rate_one_ff, rate_one_in, rate_two_ff, rate_two_in;
   logic signed [31:0] b1x_ff, b1x_in, b1y_ff, b1y_in, b2x_ff, b2x_in, b2y_ff, b2y_in;

   logic signed [31:0] res_ff, res_in, res2_ff, res2_in;
   logic signed [63:0] prod_ff, prod_in;

   logic [31:0]   rem_ff, rem_in, dvsr_ff, dvsr_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic          dneg_ff, dneg_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;

   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic           flip_ff, flip_in;
   logic [TCW-1:0] tcnt_ff, tcnt_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic signed [31:0] opa, opb, mulb;
   logic [ANGLE_BITS-1:0] ang_sel;
   logic [31:0] a32;
   logic signed [33:0] z0, xs, ys, at;
   logic [4:0] tidx;
   logic signed [32:0] sum33;
   logic signed [63:0] shv;
   logic [32:0] trial;
   logic [31:0] na, nb;
   logic signed [DW+1:0] qs;
   logic signed [34:0] tx, ty;
   logic out_free;

   assign fetch_uop = prog_rom(pc_ff);
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (uop_ff.src_a)
         SRC_L1:   opa = $signed({5'b0, len1_ff});
         SRC_L2:   opa = $signed({5'b0, len2_ff});
         SRC_M1:   opa = $signed({5'b0, mass1_ff});
         SRC_M2:   opa = $signed({5'b0, mass2_ff});
         SRC_G:    opa = $signed({5'b0, grav_ff});
         SRC_W1:   opa = rate_one_ff;
         SRC_W2:   opa = rate_two_ff;
         SRC_PX:   opa = 32'(pivx_ff);
         SRC_PY:   opa = 32'(pivy_ff);
         SRC_ZERO: opa = '0;
         SRC_B1X:  opa = b1x_ff;
         SRC_B1Y:  opa = b1y_ff;
         default:  opa = rfa_ff;
      endcase
   end

   always_comb begin
      case (uop_ff.src_b)
         SRC_L1:   opb = $signed({5'b0, len1_ff});
         SRC_L2:   opb = $signed({5'b0, len2_ff});
         SRC_M1:   opb = $signed({5'b0, mass1_ff});
         SRC_M2:   opb = $signed({5'b0, mass2_ff});
         SRC_G:    opb = $signed({5'b0, grav_ff});
         SRC_W1:   opb = rate_one_ff;
         SRC_W2:   opb = rate_two_ff;
         SRC_PX:   opb = 32'(pivx_ff);
         SRC_PY:   opb = 32'(pivy_ff);
         SRC_ZERO: opb = '0;
         SRC_B1X:  opb = b1x_ff;
         SRC_B1Y:  opb = b1y_ff;
         default:  opb = rfb_ff;
      endcase
   end

   always_comb begin
      case (uop_ff.src_a)
         ANG_T1:  ang_sel = angle_one_ff;
         ANG_T2:  ang_sel = angle_two_ff;
         ANG_D:   ang_sel = ANGLE_BITS'(angle_one_ff - angle_two_ff);
         ANG_T12: ang_sel = ANGLE_BITS'(angle_one_ff - (angle_two_ff << 1));
         ANG_2D:  ang_sel = ANGLE_BITS'((angle_one_ff - angle_two_ff) << 1);
         default: ang_sel = angle_one_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      uop_in       = uop_ff;
      len1_in      = len1_ff;
      len2_in      = len2_ff;
      mass1_in     = mass1_ff;
      mass2_in     = mass2_ff;
      grav_in      = grav_ff;
      damp_in      = damp_ff;
      pivx_in      = pivx_ff;
      pivy_in      = pivy_ff;
      angle_one_in = angle_one_ff;
      angle_two_in = angle_two_ff;
      rate_one_in  = rate_one_ff;
      rate_two_in  = rate_two_ff;
      b1x_in       = b1x_ff;
      b1y_in       = b1y_ff;
      b2x_in       = b2x_ff;
      b2y_in       = b2y_ff;
      res_in       = res_ff;
      res2_in      = res2_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      dvsr_in      = dvsr_ff;
      quo_in       = quo_ff;
      dneg_in      = dneg_ff;
      dcnt_in      = dcnt_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      flip_in      = flip_ff;
      tcnt_in      = tcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rf_we        = 1'b0;
      rf_waddr     = uop_ff.dst[3:0];
      rf_wdata     = res_ff;

      mulb  = opb;
      a32   = 32'(ang_sel) << (32 - ANGLE_BITS);
      z0    = $signed({{2{a32[31]}}, a32});
      tidx  = 5'(tcnt_ff);
      xs    = x_ff >>> tidx;
      ys    = y_ff >>> tidx;
      at    = $signed(34'(atan_turn(tidx)));
      sum33 = 33'(opa) + 33'(opb);
      shv   = prod_ff >>> FRAC_BITS;
      trial = {rem_ff, quo_ff[DW-1]};
      na    = opa[31] ? 32'(-33'(opa)) : 32'(opa);
      nb    = opb[31] ? 32'(-33'(opb)) : 32'(opb);
      qs    = $signed({2'b00, quo_ff});
      tx    = 35'(x_ff >>> TRIG_SH);
      ty    = 35'(y_ff >>> TRIG_SH);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ARM_LENGTH_ONE: len1_in  = csr_data[26:0];
            CSR_ARM_LENGTH_TWO: len2_in  = csr_data[26:0];
            CSR_BOB_MASS_ONE:   mass1_in = csr_data[26:0];
            CSR_BOB_MASS_TWO:   mass2_in = csr_data[26:0];
            CSR_GRAVITY_ACCEL:  grav_in  = csr_data[26:0];
            CSR_DAMPING_FACTOR: damp_in  = csr_data[16:0];
            CSR_PIVOT_X:        pivx_in  = $signed(csr_data);
            CSR_PIVOT_Y:        pivy_in  = $signed(csr_data);
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.func) begin
                  angle_one_in = req_data.start_angle_one[ANGLE_BITS-1:0];
                  angle_two_in = req_data.start_angle_two[ANGLE_BITS-1:0];
                  rate_one_in  = '0;
                  rate_two_in  = '0;
               end
               pc_in    = '0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            uop_in   = fetch_uop;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (uop_ff.op)
               OP_ADD: begin
                  res_in   = sat32(66'(sum33));
                  state_in = ST_WRITE;
               end
               OP_SUB: begin
                  sum33    = 33'(opa) - 33'(opb);
                  res_in   = sat32(66'(sum33));
                  state_in = ST_WRITE;
               end
               OP_MUL, OP_DAMP, OP_ADV: begin
                  if (uop_ff.op == OP_DAMP) begin
                     mulb = $signed({15'b0, damp_ff});
                  end else if (uop_ff.op == OP_ADV) begin
                     mulb = RAD_TO_TURN;
                  end
                  prod_in  = 64'(opa) * 64'(mulb);
                  state_in = ST_MRES;
               end
               OP_DIV: begin
                  if (opb == '0) begin
                     res_in   = opa[31] ? Q_MIN : ((opa == '0) ? 32'sd0 : Q_MAX);
                     state_in = ST_WRITE;
                  end else begin
                     quo_in   = DW'({na, {FRAC_BITS{1'b0}}});
                     rem_in   = '0;
                     dvsr_in  = nb;
                     dneg_in  = opa[31] ^ opb[31];
                     dcnt_in  = '0;
                     state_in = ST_DIV;
                  end
               end
               OP_TRIG: begin
                  flip_in = 1'b0;
                  z_in    = z0;
                  if (z0 >= 34'sd1073741824) begin
                     z_in    = z0 - 34'sd2147483648;
                     flip_in = 1'b1;
                  end else if (z0 < -34'sd1073741824) begin
                     z_in    = z0 + 34'sd2147483648;
                     flip_in = 1'b1;
                  end
                  x_in     = TRIG_GAIN;
                  y_in     = '0;
                  tcnt_in  = '0;
                  state_in = ST_TRIG;
               end
               default: state_in = ST_WRITE;
            endcase
         end
         ST_MRES: begin
            case (uop_ff.op)
               OP_DAMP: res_in = sat32(66'(prod_ff >>> 16));
               OP_ADV:  res_in = 32'(prod_ff >>> ADV_SH);
               default: res_in = sat32(66'(shv));
            endcase
            state_in = ST_WRITE;
         end
         ST_DIV: begin
            if (dcnt_ff == DCW'(DW)) begin
               res_in   = sat32(66'(dneg_ff ? -qs : qs));
               state_in = ST_WRITE;
            end else begin
               if (trial >= {1'b0, dvsr_ff}) begin
                  rem_in = 32'(trial - {1'b0, dvsr_ff});
                  quo_in = {quo_ff[DW-2:0], 1'b1};
               end else begin
                  rem_in = trial[31:0];
                  quo_in = {quo_ff[DW-2:0], 1'b0};
               end
               dcnt_in = dcnt_ff + 1'b1;
            end
         end
         ST_TRIG: begin
            if (tcnt_ff == TCW'(NSTEP)) begin
               res_in   = sat32(66'(flip_ff ? -ty : ty));
               res2_in  = sat32(66'(flip_ff ? -tx : tx));
               state_in = ST_WRITE;
            end else begin
               if (z_ff >= 0) begin
                  x_in = x_ff - ys;
                  y_in = y_ff + xs;
                  z_in = z_ff - at;
               end else begin
                  x_in = x_ff + ys;
                  y_in = y_ff - xs;
                  z_in = z_ff + at;
               end
               tcnt_in = tcnt_ff + 1'b1;
            end
         end
         ST_WRITE, ST_WRITE2: begin
            if (state_ff == ST_WRITE2) begin
               rf_we    = 1'b1;
               rf_waddr = uop_ff.dst[3:0] + 4'd1;
               rf_wdata = res2_ff;
            end else begin
               case (uop_ff.dst)
                  DST_W1:  rate_one_in  = res_ff;
                  DST_W2:  rate_two_in  = res_ff;
                  DST_A1:  angle_one_in = angle_one_ff + ANGLE_BITS'(res_ff);
                  DST_A2:  angle_two_in = angle_two_ff + ANGLE_BITS'(res_ff);
                  DST_B1X: b1x_in = res_ff;
                  DST_B1Y: b1y_in = res_ff;
                  DST_B2X: b2x_in = res_ff;
                  DST_B2Y: b2y_in = res_ff;
                  default: rf_we = 1'b1;
               endcase
            end
            if (state_ff == ST_WRITE && uop_ff.op == OP_TRIG) begin
               state_in = ST_WRITE2;
            end else if (pc_ff == PC_BITS'(PROG_LEN - 1)) begin
               state_in = ST_DONE;
            end else begin
               pc_in    = pc_ff + 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.angle_one = 32'(angle_one_ff);
               rsp_data_in.angle_two = 32'(angle_two_ff);
               rsp_data_in.rate_one  = rate_one_ff;
               rsp_data_in.rate_two  = rate_two_ff;
               rsp_data_in.bob_one_x = b1x_ff;
               rsp_data_in.bob_one_y = b1y_ff;
               rsp_data_in.bob_two_x = b2x_ff;
               rsp_data_in.bob_two_y = b2y_ff;
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // register file: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf[rf_waddr] <= rf_wdata;
      end
      if (state_ff == ST_FETCH) begin
         rfa_ff <= rf[fetch_uop.src_a[3:0]];
         rfb_ff <= rf[fetch_uop.src_b[3:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         len1_ff      <= 27'd9830400;
         len2_ff      <= 27'd9830400;
         mass1_ff     <= 27'd1310720;
         mass2_ff     <= 27'd1310720;
         grav_ff      <= 27'd65536;
         damp_ff      <= 17'd65470;
         pivx_ff      <= 28'sd26214400;
         pivy_ff      <= 28'sd13107200;
         angle_one_ff <= '0;
         angle_two_ff <= '0;
         rate_one_ff  <= '0;
         rate_two_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         len1_ff      <= len1_in;
         len2_ff      <= len2_in;
         mass1_ff     <= mass1_in;
         mass2_ff     <= mass2_in;
         grav_ff      <= grav_in;
         damp_ff      <= damp_in;
         pivx_ff      <= pivx_in;
         pivy_ff      <= pivy_in;
         angle_one_ff <= angle_one_in;
         angle_two_ff <= angle_two_in;
         rate_one_ff  <= rate_one_in;
         rate_two_ff  <= rate_two_in;
      end
   end

   always_ff @(posedge clock) begin
      uop_ff      <= uop_in;
      b1x_ff      <= b1x_in;
      b1y_ff      <= b1y_in;
      b2x_ff      <= b2x_in;
      b2y_ff      <= b2y_in;
      res_ff      <= res_in;
      res2_ff     <= res2_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      dvsr_ff     <= dvsr_in;
      quo_ff      <= quo_in;
      dneg_ff     <= dneg_in;
      dcnt_ff     <= dcnt_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      flip_ff     <= flip_in;
      tcnt_ff     <= tcnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (pc_ff < PC_BITS'(PROG_LEN)))
      else $error("program counter past end of program");

   a_load_clears_rates: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.func) |=>
      (rate_one_ff == '0 && rate_two_ff == '0))
      else $error("load beat did not clear rates");

   a_done_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished tick not presented");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (dcnt_ff <= DCW'(DW)))
      else $error("divider ran past its width");

   a_trig_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRIG) |-> (tcnt_ff <= TCW'(NSTEP)))
      else $error("rotator ran past its step count");

endmodule
